// ===== rtl/core/atp_pkg.sv =====
package atp_pkg;

    localparam int DEFAULT_MAX_PARTS = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_SEPARATOR  = 2'd0;
    localparam logic [1:0] CFG_PART_COUNT = 2'd1;
    localparam logic [1:0] CFG_HEX_MODE   = 2'd2;

    localparam logic [7:0] SEPARATOR_RESET  = 8'd46;
    localparam logic [4:0] PART_COUNT_RESET = 5'd4;
    localparam logic       HEX_MODE_RESET   = 1'b0;

    // character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_I       = 8'h69;
    localparam logic [7:0] CASE_DELTA = 8'd32;
    localparam logic [7:0] HEX_BASE   = CH_UPPER_A - 8'd10;

    typedef enum logic [2:0] {
        PH_START,
        PH_CONST,
        PH_BR_A0,
        PH_BR_A,
        PH_BR_B,
        PH_BR_I,
        PH_BR_END
    } t_phase;

    typedef enum logic [1:0] {
        ST_PROGRESS  = 2'd0,
        ST_ACCEPT    = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

endpackage

// ===== rtl/core/address_template_parser_core.sv =====
// A result is written into the output register when its character beat is accepted.
// Throughput: one character per cycle while the input is not stalled; the parse state updates in a single pass.
// The output register frees its slot in the same cycle it is taken, so input is
// held only while a result waits and the output side stalls.
// Reset (synchronous, active low): parser at start of the first part, output empty,
// separator '.', part count 4, decimal mode.
module address_template_parser_core #(
    parameter int MAX_PARTS = atp_pkg::DEFAULT_MAX_PARTS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // character input
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_code,
    // result output
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_part_valid,
    output logic [3:0] o_part_index,
    output logic       o_part_mode,
    output logic [7:0] o_base_value,
    output logic [7:0] o_step_value,
    output logic [1:0] o_status,
    output logic       o_last,
    // configuration writes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import atp_pkg::*;

    localparam int PW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;

    // configuration
    logic [7:0] r_separator;
    logic [4:0] r_part_count;
    logic       r_hex_mode;

    // parse state
    t_phase          r_phase, n_phase;
    logic [PW-1:0]   r_part, n_part;
    logic [7:0]      r_accum, n_accum;
    logic [7:0]      r_offset, n_offset;
    logic            r_step_seen, n_step_seen;
    logic            r_linear, n_linear;
    logic            r_skip, n_skip;

    // output register
    logic       r_out_valid;
    logic       r_part_valid;
    logic [3:0] r_part_index;
    logic       r_part_mode;
    logic [7:0] r_base_value;
    logic [7:0] r_step_value;
    t_status    r_status;
    logic       r_last;

    logic       in_accept;
    logic [7:0] c, f;
    logic [7:0] c_dig, f_dig_dec, f_dig_hex;
    logic       c_is_digit, f_is_dec, f_is_hex, outer_is_digit;
    logic [3:0] outer_dig;
    logic [6:0] eff_count;
    logic       final_part;
    logic [11:0] acc_x10, acc_x16, dec_next, outer_next;
    logic [PW+3:0] part_ext;

    logic       res_fire, res_valid, res_mode, res_last;
    logic [7:0] res_base, res_step;
    t_status    res_status, fail_status;
    logic       do_fail, do_begin, do_next;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;

    assign c = i_char_code;
    assign f = (c >= CH_LOWER_A && c <= CH_LOWER_F) ? c - CASE_DELTA : c;

    assign c_dig      = c - CH_ZERO;
    assign f_dig_dec  = f - CH_ZERO;
    assign f_dig_hex  = f - HEX_BASE;
    assign c_is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign f_is_dec   = (f >= CH_ZERO) && (f <= CH_NINE);
    assign f_is_hex   = r_hex_mode && (f >= CH_UPPER_A) && (f <= CH_UPPER_F);
    assign outer_is_digit = f_is_dec | f_is_hex;
    assign outer_dig  = f_is_dec ? f_dig_dec[3:0] : f_dig_hex[3:0];

    // clamp part count into 1..MAX_PARTS
    assign eff_count = (r_part_count == 5'd0) ? 7'd1 :
                       ({2'b00, r_part_count} > 7'(MAX_PARTS)) ? 7'(MAX_PARTS) :
                       {2'b00, r_part_count};
    assign final_part = (7'(r_part) + 7'd1) >= eff_count;

    assign acc_x10    = {1'b0, r_accum, 3'b000} + {3'b000, r_accum, 1'b0};
    assign acc_x16    = {r_accum, 4'b0000};
    assign dec_next   = acc_x10 + {8'd0, c_dig[3:0]};
    assign outer_next = (r_hex_mode ? acc_x16 : acc_x10) + {8'd0, outer_dig};

    assign part_ext = (PW+4)'(r_part);

    always_comb begin
        n_phase     = r_phase;
        n_part      = r_part;
        n_accum     = r_accum;
        n_offset    = r_offset;
        n_step_seen = r_step_seen;
        n_linear    = r_linear;
        n_skip      = r_skip;
        res_fire    = 1'b0;
        res_valid   = 1'b0;
        res_mode    = 1'b0;
        res_base    = 8'd0;
        res_step    = 8'd0;
        res_status  = ST_PROGRESS;
        res_last    = 1'b0;
        do_fail     = 1'b0;
        fail_status = ST_MALFORMED;
        do_begin    = 1'b0;
        do_next     = 1'b0;

        if (r_skip) begin
            do_begin = (c == CH_NUL);
        end else begin
            unique case (r_phase)
                PH_START: begin
                    if (outer_is_digit) begin
                        n_accum  = {4'd0, outer_dig};
                        n_linear = 1'b0;
                        n_phase  = PH_CONST;
                    end else if (c == CH_LBRACE) begin
                        n_accum = 8'd0;
                        n_phase = PH_BR_A0;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                PH_CONST: begin
                    if (outer_is_digit) begin
                        if (outer_next[11:8] != 4'd0) begin
                            do_fail     = 1'b1;
                            fail_status = ST_OVERFLOW;
                        end else begin
                            n_accum = outer_next[7:0];
                        end
                    end else if (c == CH_NUL && final_part) begin
                        res_fire   = 1'b1;
                        res_valid  = 1'b1;
                        res_base   = r_accum;
                        res_status = ST_ACCEPT;
                        res_last   = 1'b1;
                        do_begin   = 1'b1;
                    end else if (c != CH_NUL && f == r_separator && !final_part) begin
                        res_fire  = 1'b1;
                        res_valid = 1'b1;
                        res_base  = r_accum;
                        do_next   = 1'b1;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                PH_BR_A0: begin
                    if (c_is_digit) begin
                        n_accum = {4'd0, c_dig[3:0]};
                        n_phase = PH_BR_A;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                PH_BR_A: begin
                    if (c_is_digit) begin
                        if (dec_next[11:8] != 4'd0) do_fail = 1'b1;
                        else n_accum = dec_next[7:0];
                    end else if (c == CH_PLUS) begin
                        n_offset    = r_accum;
                        n_accum     = 8'd0;
                        n_step_seen = 1'b0;
                        n_phase     = PH_BR_B;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                PH_BR_B: begin
                    if (c_is_digit) begin
                        if (dec_next[11:8] != 4'd0) begin
                            do_fail = 1'b1;
                        end else begin
                            n_accum     = dec_next[7:0];
                            n_step_seen = 1'b1;
                        end
                    end else if (c != CH_I) begin
                        do_fail = 1'b1;
                    end else if (r_step_seen && r_accum == 8'd0) begin
                        do_fail = 1'b1;   // explicit zero step
                    end else begin
                        if (!r_step_seen) n_accum = 8'd1;
                        n_phase = PH_BR_I;
                    end
                end
                PH_BR_I: begin
                    if (c == CH_RBRACE) begin
                        n_linear = 1'b1;
                        n_phase  = PH_BR_END;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                PH_BR_END: begin
                    // raw character compare after a closing brace
                    if (c == CH_NUL) begin
                        if (!final_part) begin
                            do_fail = 1'b1;
                        end else begin
                            res_fire   = 1'b1;
                            res_valid  = 1'b1;
                            res_mode   = r_linear;
                            res_base   = r_offset;
                            res_step   = r_accum;
                            res_status = ST_ACCEPT;
                            res_last   = 1'b1;
                            do_begin   = 1'b1;
                        end
                    end else if (c == r_separator && !final_part) begin
                        res_fire  = 1'b1;
                        res_valid = 1'b1;
                        res_mode  = r_linear;
                        res_base  = r_offset;
                        res_step  = r_accum;
                        do_next   = 1'b1;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                default: begin
                    do_fail = 1'b1;
                end
            endcase
        end

        if (do_fail) begin
            res_fire   = 1'b1;
            res_status = fail_status;
            res_last   = 1'b1;
            if (c == CH_NUL) do_begin = 1'b1;
            else n_skip = 1'b1;
        end

        if (do_next) begin
            n_part      = r_part + PW'(1);
            n_phase     = PH_START;
            n_accum     = 8'd0;
            n_offset    = 8'd0;
            n_step_seen = 1'b0;
            n_linear    = 1'b0;
        end

        if (do_begin) begin
            n_part      = '0;
            n_phase     = PH_START;
            n_accum     = 8'd0;
            n_offset    = 8'd0;
            n_step_seen = 1'b0;
            n_linear    = 1'b0;
            n_skip      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_separator  <= SEPARATOR_RESET;
            r_part_count <= PART_COUNT_RESET;
            r_hex_mode   <= HEX_MODE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SEPARATOR:  r_separator  <= i_cfg_data;
                CFG_PART_COUNT: r_part_count <= i_cfg_data[4:0];
                CFG_HEX_MODE:   r_hex_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_part      <= '0;
            r_accum     <= 8'd0;
            r_offset    <= 8'd0;
            r_step_seen <= 1'b0;
            r_linear    <= 1'b0;
            r_skip      <= 1'b0;
        end else if (in_accept) begin
            r_phase     <= n_phase;
            r_part      <= n_part;
            r_accum     <= n_accum;
            r_offset    <= n_offset;
            r_step_seen <= n_step_seen;
            r_linear    <= n_linear;
            r_skip      <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && res_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && res_fire) begin
            r_part_valid <= res_valid;
            r_part_index <= res_valid ? part_ext[3:0] : 4'd0;
            r_part_mode  <= res_mode;
            r_base_value <= res_base;
            r_step_value <= res_step;
            r_status     <= res_status;
            r_last       <= res_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_part_valid = r_part_valid;
    assign o_part_index = r_part_index;
    assign o_part_mode  = r_part_mode;
    assign o_base_value = r_base_value;
    assign o_step_value = r_step_value;
    assign o_status     = r_status;
    assign o_last       = r_last;

endmodule

// ===== verif/address_template_parser_core_chk.sv =====
module address_template_parser_core_chk #(
    parameter int MAX_PARTS = atp_pkg::DEFAULT_MAX_PARTS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic       i_part_valid,
    input  logic [3:0] i_part_index,
    input  logic       i_part_mode,
    input  logic [7:0] i_base_value,
    input  logic [7:0] i_step_value,
    input  logic [1:0] i_status,
    input  logic       i_last,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output int         o_pending,
    output int         o_error_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import atp_pkg::*;

    typedef struct packed {
        logic       part_valid;
        logic [3:0] part_index;
        logic       part_mode;
        logic [7:0] base_value;
        logic [7:0] step_value;
        t_status    status;
        logic       last;
    } t_part_result;

    // register mirror
    logic [7:0] sep_char;
    logic [4:0] part_limit;
    logic       hex_on;

    // parser state mirror
    t_phase     phase;
    logic [3:0] part_no;
    logic [8:0] accum;
    logic [7:0] offset;
    logic       step_seen;
    logic       skipping;

    t_part_result expected_parts[$];
    int errors = 0;

    assign o_error_count = errors;

    function automatic void clear_string();
        phase     = PH_START;
        part_no   = '0;
        accum     = '0;
        offset    = '0;
        step_seen = 1'b0;
        skipping  = 1'b0;
    endfunction

    function automatic void advance_part();
        part_no   = part_no + 4'd1;
        phase     = PH_START;
        accum     = '0;
        offset    = '0;
        step_seen = 1'b0;
    endfunction

    function automatic t_part_result result_of(input bit pv, input bit mode,
                                               input logic [7:0] base,
                                               input logic [7:0] step,
                                               input t_status st, input bit fin);
        t_part_result r;
        r.part_valid = pv;
        r.part_index = pv ? part_no : 4'd0;
        r.part_mode  = mode;
        r.base_value = base;
        r.step_value = step;
        r.status     = st;
        r.last       = fin;
        return r;
    endfunction

    // digit outside braces, -1 if none; f is already case folded
    function automatic int digit_value(input logic [7:0] f);
        if (f >= CH_ZERO && f <= CH_NINE) return int'(f - CH_ZERO);
        if (hex_on && f >= CH_UPPER_A && f <= CH_UPPER_F) return int'(f - HEX_BASE);
        return -1;
    endfunction

    // advances the parser by one character; returns 1 when a result is due
    function automatic bit parse_char(input logic [7:0] c, output t_part_result r);
        logic [7:0] f;
        int         lim;
        int         d;
        int         v;
        bit         final_part;
        bit         is_dig;
        bit         bad;
        t_status    err;
        f = (c >= CH_LOWER_A && c <= CH_LOWER_F) ? c - CASE_DELTA : c;
        lim = int'(part_limit);
        if (lim < 1) lim = 1;
        if (lim > MAX_PARTS) lim = MAX_PARTS;
        final_part = (int'(part_no) + 1 >= lim);
        is_dig = (c >= CH_ZERO && c <= CH_NINE);
        d = digit_value(f);
        bad = 1'b0;
        err = ST_MALFORMED;
        r = result_of(1'b0, 1'b0, 8'd0, 8'd0, ST_PROGRESS, 1'b0);

        if (skipping) begin
            if (c == CH_NUL) clear_string();
            return 1'b0;
        end

        case (phase)
            PH_START: begin
                if (d >= 0) begin
                    accum = 9'(d);
                    phase = PH_CONST;
                end else if (c == CH_LBRACE) begin
                    accum = '0;
                    phase = PH_BR_A0;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_CONST: begin
                v = int'(accum) * (hex_on ? 16 : 10) + d;
                if (d >= 0) begin
                    if (v > 255) begin
                        bad = 1'b1;
                        err = ST_OVERFLOW;
                    end else begin
                        accum = 9'(v);
                    end
                end else if (c == CH_NUL && final_part) begin
                    r = result_of(1'b1, 1'b0, accum[7:0], 8'd0, ST_ACCEPT, 1'b1);
                    clear_string();
                    return 1'b1;
                end else if (c != CH_NUL && f == sep_char && !final_part) begin
                    r = result_of(1'b1, 1'b0, accum[7:0], 8'd0, ST_PROGRESS, 1'b0);
                    advance_part();
                    return 1'b1;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_BR_A0: begin
                if (is_dig) begin
                    accum = 9'(c - CH_ZERO);
                    phase = PH_BR_A;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_BR_A, PH_BR_B: begin
                if (is_dig) begin
                    v = int'(accum) * 10 + int'(c - CH_ZERO);
                    if (v > 255) begin
                        bad = 1'b1;
                    end else begin
                        accum = 9'(v);
                        if (phase == PH_BR_B) step_seen = 1'b1;
                    end
                end else if (phase == PH_BR_A) begin
                    if (c == CH_PLUS) begin
                        offset    = accum[7:0];
                        accum     = '0;
                        step_seen = 1'b0;
                        phase     = PH_BR_B;
                    end else begin
                        bad = 1'b1;
                    end
                end else if (c != CH_I || (step_seen && accum == '0)) begin
                    bad = 1'b1;
                end else begin
                    // "{a+i}" means a step of one
                    if (!step_seen) accum = 9'd1;
                    phase = PH_BR_I;
                end
            end
            PH_BR_I: begin
                if (c == CH_RBRACE) phase = PH_BR_END;
                else bad = 1'b1;
            end
            PH_BR_END: begin
                // raw compare here, no case folding after a closing brace
                if (c == CH_NUL && final_part) begin
                    r = result_of(1'b1, 1'b1, offset, accum[7:0], ST_ACCEPT, 1'b1);
                    clear_string();
                    return 1'b1;
                end else if (c != CH_NUL && c == sep_char && !final_part) begin
                    r = result_of(1'b1, 1'b1, offset, accum[7:0], ST_PROGRESS, 1'b0);
                    advance_part();
                    return 1'b1;
                end else begin
                    bad = 1'b1;
                end
            end
            default: bad = 1'b1;
        endcase

        if (!bad) return 1'b0;
        r = result_of(1'b0, 1'b0, 8'd0, 8'd0, err, 1'b1);
        if (c == CH_NUL) clear_string();
        else skipping = 1'b1;
        return 1'b1;
    endfunction

    task automatic report_error(input string msg);
        $display("%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) report_error($sformatf("%s: got %0d, expected %0d", name, got, want));
    endtask

    always @(posedge i_clk) begin : monitor
        t_part_result predicted;
        if (!i_rst_n) begin
            sep_char   = SEPARATOR_RESET;
            part_limit = PART_COUNT_RESET;
            hex_on     = HEX_MODE_RESET;
            clear_string();
            expected_parts.delete();
            o_pending <= 0;
        end else begin
            // compare before predicting: a result never leaves in its own char's beat
            if (i_out_valid && !i_out_stall) begin
                if (expected_parts.size() == 0) begin
                    report_error($sformatf("result beat with nothing expected, status %0d",
                                           i_status));
                end else begin
                    predicted = expected_parts.pop_front();
                    check_field("part_valid", 8'(i_part_valid), 8'(predicted.part_valid));
                    check_field("part_index", 8'(i_part_index), 8'(predicted.part_index));
                    check_field("part_mode", 8'(i_part_mode), 8'(predicted.part_mode));
                    check_field("base_value", i_base_value, predicted.base_value);
                    check_field("step_value", i_step_value, predicted.step_value);
                    check_field("status", 8'(i_status), 8'(predicted.status));
                    check_field("last", 8'(i_last), 8'(predicted.last));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (parse_char(i_char_code, predicted)) expected_parts.push_back(predicted);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SEPARATOR:  sep_char   = i_cfg_data;
                    CFG_PART_COUNT: part_limit = i_cfg_data[4:0];
                    CFG_HEX_MODE:   hex_on     = i_cfg_data[0];
                    default: ;
                endcase
            end
            o_pending <= expected_parts.size();
        end
    end

endmodule

// ===== verif/address_template_parser_core_tb.sv =====
module address_template_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import atp_pkg::*;

    localparam int N_PARTS      = DEFAULT_MAX_PARTS;
    localparam int RANDOM_CHARS = 1300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_SETTINGS   = 8;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_char_code = '0;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data  = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_part_valid;
    logic [3:0] o_part_index;
    logic       o_part_mode;
    logic [7:0] o_base_value;
    logic [7:0] o_step_value;
    logic [1:0] o_status;
    logic       o_last;
    logic       o_cfg_ready;

    int pending;
    int error_count;
    int cycle_count = 0;
    int chars_sent  = 0;
    bit calm        = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;

    // mirror of what has been written, used to shape templates
    logic [7:0] tb_sep   = SEPARATOR_RESET;
    logic [4:0] tb_count = PART_COUNT_RESET;
    logic       tb_hex   = HEX_MODE_RESET;

    logic [7:0] text_q[$];

    // settings walked by the random part: '.', ':', 0xFF, '-', 'A', NUL, 'a', '/'
    logic [7:0] sep_table[N_SETTINGS]   = '{8'h2E, 8'h3A, 8'hFF, 8'h2D,
                                            8'h41, 8'h00, 8'h61, 8'h2F};
    logic [4:0] count_table[N_SETTINGS] = '{5'd4, 5'd16, 5'd1, 5'd2, 5'd3, 5'd0, 5'd31, 5'd5};
    logic       hex_table[N_SETTINGS]   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    string directed_strs[6] = '{"", "9", "255.{0+i}", "{1+0i}", "256", "7.3z"};

    address_template_parser_core #(
        .MAX_PARTS(N_PARTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_char_code(i_char_code),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_part_valid(o_part_valid),
        .o_part_index(o_part_index),
        .o_part_mode(o_part_mode),
        .o_base_value(o_base_value),
        .o_step_value(o_step_value),
        .o_status(o_status),
        .o_last(o_last),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    address_template_parser_core_chk #(
        .MAX_PARTS(N_PARTS)
    ) chk (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_stall(o_in_stall),
        .i_char_code(i_char_code),
        .i_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_part_valid(o_part_valid),
        .i_part_index(o_part_index),
        .i_part_mode(o_part_mode),
        .i_base_value(o_base_value),
        .i_step_value(o_step_value),
        .i_status(o_status),
        .i_last(o_last),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_pending(pending),
        .o_error_count(error_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // output side: random stall bursts, plus one long hold-off to back up the input
    always begin : out_stall_gen
        int n;
        @(posedge i_clk);
        if (hold_req && !hold_done) begin
            i_out_stall <= 1'b1;
            repeat (60) @(posedge i_clk);
            hold_done = 1'b1;
            i_out_stall <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 6);
            i_out_stall <= 1'b1;
            repeat (n) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SEPARATOR:  tb_sep   = val;
            CFG_PART_COUNT: tb_count = val[4:0];
            CFG_HEX_MODE:   tb_hex   = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_text();
        int gap;
        foreach (text_q[k]) begin
            if (!calm && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 6);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid  <= 1'b1;
            i_char_code <= text_q[k];
            do @(posedge i_clk); while (o_in_stall);
            chars_sent++;
        end
        text_q.delete();
    endtask

    // drain: every expected result out, then idle clocks so a char with no result is through too
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic push_str(input string s);
        for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
    endtask

    task automatic push_num(input int val, input bit as_hex);
        string s;
        logic [7:0] ch;
        s = as_hex ? $sformatf("%0h", val) : $sformatf("%0d", val);
        if ($urandom_range(0, 7) == 0) text_q.push_back(CH_ZERO);
        for (int k = 0; k < s.len(); k++) begin
            ch = s[k];
            if (ch >= CH_LOWER_A && ch <= CH_LOWER_F && $urandom_range(0, 1) == 1)
                ch = ch - CASE_DELTA;
            text_q.push_back(ch);
        end
    endtask

    function automatic int pick_byte();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 7))
            0, 1: return CH_ZERO + 8'($urandom_range(0, 9));
            2:    return CH_LOWER_A + 8'($urandom_range(0, 5));
            3:    return CH_UPPER_A + 8'($urandom_range(0, 5));
            4: begin
                case ($urandom_range(0, 3))
                    0:       return CH_LBRACE;
                    1:       return CH_RBRACE;
                    2:       return CH_PLUS;
                    default: return CH_I;
                endcase
            end
            5:       return tb_sep;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic build_template();
        int parts;
        int b;
        parts = (tb_count < 1) ? 1 : ((tb_count > N_PARTS) ? N_PARTS : int'(tb_count));
        for (int k = 0; k < parts; k++) begin
            if (k > 0) text_q.push_back(tb_sep);
            if ($urandom_range(0, 1) == 1) begin
                push_num(pick_byte(), tb_hex);
            end else begin
                text_q.push_back(CH_LBRACE);
                push_num(pick_byte(), 1'b0);
                text_q.push_back(CH_PLUS);
                if ($urandom_range(0, 4) != 0) begin
                    b = pick_byte();
                    push_num((b == 0) ? 1 : b, 1'b0);
                end
                text_q.push_back(CH_I);
                text_q.push_back(CH_RBRACE);
            end
        end
    endtask

    task automatic damage_text();
        int pos;
        pos = $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(0, 5))
            0: text_q[pos] = pick_char();
            1: text_q.insert(pos, pick_char());
            2: text_q.delete(pos);
            3: while (text_q.size() > pos) void'(text_q.pop_back());
            4: text_q.push_back(pick_char());
            default: repeat (3) text_q.insert(pos, CH_ZERO + 8'($urandom_range(0, 9)));
        endcase
    endtask

    initial begin : stimulus
        int first_random;
        int phase_end;
        int kind;
        do @(posedge i_clk); while (!i_rst_n);

        // directed strings under a part count of two, decimal, '.' separator
        write_reg(CFG_PART_COUNT, 8'd2);
        foreach (directed_strs[k]) begin
            push_str(directed_strs[k]);
            text_q.push_back(CH_NUL);
        end
        send_text();
        settle();

        // part count lowered mid-string: the part in progress becomes the last one
        write_reg(CFG_PART_COUNT, 8'd4);
        push_str("1.2.");
        send_text();
        settle();
        write_reg(CFG_PART_COUNT, 8'd2);
        push_str("3");
        text_q.push_back(CH_NUL);
        send_text();
        settle();

        first_random = chars_sent;
        for (int p = 0; p < N_SETTINGS; p++) begin
            write_reg(CFG_SEPARATOR, sep_table[p]);
            write_reg(CFG_PART_COUNT, 8'(count_table[p]));
            write_reg(CFG_HEX_MODE, 8'(hex_table[p]));
            phase_end = first_random + (p + 1) * RANDOM_CHARS / N_SETTINGS;
            while (chars_sent < phase_end) begin
                if (chars_sent > first_random + 300) hold_req = 1'b1;
                if (chars_sent > first_random + RANDOM_CHARS * 17 / 20) calm = 1'b1;
                kind = $urandom_range(0, 9);
                if (kind < 9) begin
                    build_template();
                    if (kind >= 7) damage_text();
                end else begin
                    repeat ($urandom_range(0, 10)) text_q.push_back(pick_char());
                end
                text_q.push_back(CH_NUL);
                send_text();
            end
            settle();
        end

        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/atp_pkg.sv
rtl/core/address_template_parser_core.sv
verif/address_template_parser_core_chk.sv
verif/address_template_parser_core_tb.sv
